/* sv/cras_pkg.sv */
// Shared types and codes for the clock replacement active set.
// Used by cras_ctrl, the top level and the checker; no dependencies.
package cras_pkg;

	// Operation codes carried on the input tuser
	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_ACCESS = 1'b1;

	// Configuration register indexes
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_ENABLE   = 1'b1;

	localparam int CAP_BITS = 7;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_OFF  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_SWEEP,
		S_SWSTEP,
		S_VICT,
		S_PRED,
		S_FREE,
		S_APPEND,
		S_RESP
	} state_t;

	typedef struct packed {
		logic    victim_valid;
		status_t status;
	} res_info_t;

endpackage

/* sv/cras_ram.sv */
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies; used by cras_ctrl for the key and link stores.
module cras_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* sv/cras_ctrl.sv */
// Sequencer for the active set: key search, clock sweep, unlink and append.
// Depends on cras_pkg and cras_ram (key store and next-slot links).
module cras_ctrl #(
	parameter int MAX_ENTRIES = 64,
	parameter int KEY_BITS    = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          func,
	input  logic [KEY_BITS-1:0]           key,
	input  logic [cras_pkg::CAP_BITS-1:0] capacity,
	input  logic                          enable,
	output logic                          ready,
	output logic                          res_valid,
	input  logic                          res_take,
	output cras_pkg::res_info_t           res_info,
	output logic [KEY_BITS-1:0]           res_key
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] SCAN_END = CW'(MAX_ENTRIES);

	cras_pkg::state_t state_q, state_d;

	logic                    func_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [CW-1:0]           scan_q;
	logic                    pend_s1;
	logic [AW-1:0]           pidx_s1;
	logic [AW-1:0]           free_q;
	logic                    free_fnd_q;
	logic [AW-1:0]           hand_q, head_q, tail_q, victim_q, vnext_q, p_q;
	logic [CW-1:0]           occ_q;
	logic [KEY_BITS-1:0]     vkey_q;
	logic                    vval_q;
	cras_pkg::status_t       status_q;
	logic [MAX_ENTRIES-1:0]  refb_q, valid_q;

	logic                k_we, n_we;
	logic [AW-1:0]       k_waddr, k_raddr, n_waddr, n_raddr, n_wdata, n_rdata;
	logic [KEY_BITS-1:0] k_wdata, k_rdata;

	logic        hit, scan_done, need_evict;
	logic [31:0] cap_eff;

	cras_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(KEY_BITS), .AW(AW)) u_key_ram (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	cras_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(AW), .AW(AW)) u_next_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);

	// Clamp the capacity into 1..MAX_ENTRIES
	always_comb begin
		cap_eff = {{(32-cras_pkg::CAP_BITS){1'b0}}, capacity};
		if (cap_eff == 32'd0) begin
			cap_eff = 32'd1;
		end else if (cap_eff > 32'(MAX_ENTRIES)) begin
			cap_eff = 32'(MAX_ENTRIES);
		end
	end

	assign need_evict = (occ_q != '0) && ({{(32-CW){1'b0}}, occ_q} >= cap_eff);
	assign hit        = pend_s1 && valid_q[pidx_s1] && (k_rdata == key_q);
	assign scan_done  = (scan_q == SCAN_END) && !pend_s1;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cras_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control
	always_comb begin
		state_d = state_q;
		k_we    = 1'b0;
		k_waddr = free_q;
		k_wdata = key_q;
		k_raddr = scan_q[AW-1:0];
		n_we    = 1'b0;
		n_waddr = p_q;
		n_wdata = vnext_q;
		n_raddr = hand_q;
		unique case (state_q)
			cras_pkg::S_IDLE: begin
				if (start) begin
					state_d = enable ? cras_pkg::S_FIND : cras_pkg::S_RESP;
				end
			end
			cras_pkg::S_FIND: begin
				if (hit) begin
					state_d = cras_pkg::S_RESP;
				end else if (scan_done) begin
					if (func_q == cras_pkg::FUNC_ACCESS) begin
						state_d = cras_pkg::S_RESP;
					end else if (need_evict) begin
						state_d = cras_pkg::S_SWEEP;
					end else begin
						state_d = cras_pkg::S_APPEND;
					end
				end
			end
			cras_pkg::S_SWEEP: begin
				k_raddr = hand_q;
				state_d = refb_q[hand_q] ? cras_pkg::S_SWSTEP : cras_pkg::S_VICT;
			end
			cras_pkg::S_SWSTEP: begin
				state_d = cras_pkg::S_SWEEP;
			end
			cras_pkg::S_VICT: begin
				if (victim_q == head_q) begin
					state_d = cras_pkg::S_FREE;
				end else begin
					n_raddr = head_q;
					state_d = cras_pkg::S_PRED;
				end
			end
			cras_pkg::S_PRED: begin
				if (n_rdata == victim_q) begin
					n_we    = 1'b1;
					state_d = cras_pkg::S_FREE;
				end else begin
					n_raddr = n_rdata;
				end
			end
			cras_pkg::S_FREE: begin
				state_d = cras_pkg::S_APPEND;
			end
			cras_pkg::S_APPEND: begin
				if (free_fnd_q) begin
					k_we = 1'b1;
					if (occ_q != '0) begin
						n_we    = 1'b1;
						n_waddr = tail_q;
						n_wdata = free_q;
					end
				end
				state_d = cras_pkg::S_RESP;
			end
			cras_pkg::S_RESP: begin
				if (res_take) begin
					state_d = cras_pkg::S_IDLE;
				end
			end
			default: state_d = cras_pkg::S_IDLE;
		endcase
	end

	// Set bookkeeping: reference and valid bits, list ends, hand, occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refb_q     <= '0;
			valid_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			hand_q     <= '0;
			occ_q      <= '0;
			pend_s1    <= 1'b0;
			free_fnd_q <= 1'b0;
		end else begin
			case (state_q)
				cras_pkg::S_IDLE: begin
					if (start) begin
						pend_s1    <= 1'b0;
						free_fnd_q <= 1'b0;
					end
				end
				cras_pkg::S_FIND: begin
					if (hit) begin
						if (func_q == cras_pkg::FUNC_ACCESS) begin
							refb_q[pidx_s1] <= 1'b1;
						end
					end else if (!scan_done) begin
						if (scan_q != SCAN_END) begin
							pend_s1 <= 1'b1;
							if (!valid_q[scan_q[AW-1:0]] && !free_fnd_q) begin
								free_fnd_q <= 1'b1;
							end
						end else begin
							pend_s1 <= 1'b0;
						end
					end
				end
				cras_pkg::S_SWEEP: begin
					if (refb_q[hand_q]) begin
						refb_q[hand_q] <= 1'b0;
					end
				end
				cras_pkg::S_SWSTEP: begin
					hand_q <= (hand_q == tail_q) ? head_q : n_rdata;
				end
				cras_pkg::S_VICT: begin
					hand_q <= (victim_q == tail_q) ? head_q : n_rdata;
					if (victim_q == head_q) begin
						head_q <= n_rdata;
					end
				end
				cras_pkg::S_PRED: begin
					if (n_rdata == victim_q && victim_q == tail_q) begin
						tail_q <= p_q;
					end
				end
				cras_pkg::S_FREE: begin
					valid_q[victim_q] <= 1'b0;
					refb_q[victim_q]  <= 1'b0;
					occ_q             <= occ_q - 1'b1;
					free_fnd_q        <= 1'b1;
				end
				cras_pkg::S_APPEND: begin
					if (free_fnd_q) begin
						refb_q[free_q]  <= 1'b1;
						valid_q[free_q] <= 1'b1;
						occ_q           <= occ_q + 1'b1;
						tail_q          <= free_q;
						if (occ_q == '0) begin
							head_q <= free_q;
							hand_q <= free_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Transaction payload and scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			cras_pkg::S_IDLE: begin
				if (start) begin
					key_q    <= key;
					func_q   <= func;
					scan_q   <= '0;
					vval_q   <= 1'b0;
					vkey_q   <= '0;
					status_q <= enable ? cras_pkg::ST_OK : cras_pkg::ST_OFF;
				end
			end
			cras_pkg::S_FIND: begin
				if (hit) begin
					if (func_q != cras_pkg::FUNC_ACCESS) begin
						status_q <= cras_pkg::ST_DUP;
					end
				end else if (scan_done) begin
					if (func_q == cras_pkg::FUNC_ACCESS) begin
						status_q <= cras_pkg::ST_MISS;
					end
				end else if (scan_q != SCAN_END) begin
					pidx_s1 <= scan_q[AW-1:0];
					if (!valid_q[scan_q[AW-1:0]] && !free_fnd_q) begin
						free_q <= scan_q[AW-1:0];
					end
					scan_q <= scan_q + 1'b1;
				end
			end
			cras_pkg::S_SWEEP: begin
				victim_q <= hand_q;
			end
			cras_pkg::S_VICT: begin
				vkey_q  <= k_rdata;
				vnext_q <= n_rdata;
				vval_q  <= 1'b1;
				p_q     <= head_q;
			end
			cras_pkg::S_PRED: begin
				if (n_rdata != victim_q) begin
					p_q <= n_rdata;
				end
			end
			cras_pkg::S_FREE: begin
				if (!free_fnd_q || victim_q < free_q) begin
					free_q <= victim_q;
				end
			end
			default: ;
		endcase
	end

	assign ready                 = (state_q == cras_pkg::S_IDLE);
	assign res_valid             = (state_q == cras_pkg::S_RESP);
	assign res_info.victim_valid = vval_q;
	assign res_info.status       = status_q;
	assign res_key               = vkey_q;

endmodule

/* sv/clock_replacement_active_set_core.sv */
// Clock replacement active set: top level with configuration and output register.
// Depends on cras_pkg and cras_ctrl.
//
// Input stream: s_tuser selects add (0) or access (1), s_tdata carries the key.
// Output stream: one transaction per input; m_tdata holds the evicted key
// (zero when none), m_tuser holds the eviction flag and the status code.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 capacity,
// 1 enable) at the clock edge; write only while the block is idle.
// Operation: the key store is scanned one slot a cycle and a hit ends the scan;
// a miss scans every slot. An evicting add then runs the clock sweep, clearing
// set reference bits until the hand finds a clear one, and, unless the victim is
// the head, walks the list from its head to the victim's predecessor to unlink
// it. A disabled operation skips the search. The block takes one transaction at
// a time and is ready again from the clock edge that loads its result into the
// output register.
// Reset clears the set, the hand and occupancy; capacity returns to 64 and
// tracking is enabled. A stalled receiver holds the result in the output
// register; the next transaction is accepted meanwhile and waits for it.
module clock_replacement_active_set_core #(
	parameter int MAX_ENTRIES = 64,
	parameter int KEY_BITS    = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((KEY_BITS+7)/8)*8-1:0] s_tdata,  // entry_key
	input  logic                          s_tuser,  // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [((KEY_BITS+7)/8)*8-1:0] m_tdata,  // victim_key
	output logic [2:0]                    m_tuser,  // victim_valid, op_status
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [cras_pkg::CAP_BITS-1:0] cfg_wdata
);

	localparam int TDW = ((KEY_BITS+7)/8)*8;

	logic [cras_pkg::CAP_BITS-1:0] cap_q;
	logic                          en_q;
	logic                          start, ready, res_valid, res_take;
	cras_pkg::res_info_t           res_info;
	logic [KEY_BITS-1:0]           res_key;
	logic                          m_tvalid_q;
	logic [TDW-1:0]                m_tdata_q;
	logic [2:0]                    m_tuser_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cras_pkg::CAP_BITS'(64);
			en_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				cras_pkg::REG_CAPACITY: cap_q <= cfg_wdata;
				cras_pkg::REG_ENABLE:   en_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign s_tready = ready;
	assign start    = s_tvalid && ready;
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	cras_ctrl #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_BITS(KEY_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .func(s_tuser),
		.key(s_tdata[KEY_BITS-1:0]), .capacity(cap_q), .enable(en_q),
		.ready(ready), .res_valid(res_valid), .res_take(res_take),
		.res_info(res_info), .res_key(res_key)
	);

	// Output register: load a finished result, hold it while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= TDW'(res_key);
			m_tuser_q <= {res_info.status, res_info.victim_valid};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* sv/cras_checker.sv */
// Port-level checks for the clock replacement active set, bound to the top.
// Depends on cras_pkg and clock_replacement_active_set_core.
module cras_checker #(
	parameter int KEY_BITS = 48
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [((KEY_BITS+7)/8)*8-1:0] m_tdata,
	input logic [2:0]                    m_tuser
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// One transaction at a time: ready drops after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted while busy");

	// An eviction only comes with a plain ok status
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == cras_pkg::ST_OK)
		else $error("eviction with error status");

	// No eviction means a zero key
	a_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("key without eviction");

endmodule

bind clock_replacement_active_set_core cras_checker #(.KEY_BITS(KEY_BITS)) u_cras_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
